### rtl/sorted_priority_queue_defines.svh
// Assertion macros used by the bound property checker
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held low
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spq_pkg.sv
package spq_pkg;

    // Fixed field widths of the request and result
    localparam int FUNC_W      = 2;
    localparam int VAL_IN_W    = 32;
    localparam int PRIO_W      = 16;
    localparam int CFG_W       = 10;
    localparam int COUNT_OUT_W = 10;

    // Capacity limit after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 10'd500;

    // Function codes on the request port
    localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLR  = 2'd3;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_PEEK,
        OP_CLR
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Classified request handed from front to back
    typedef struct packed {
        t_op                       op;
        logic [VAL_IN_W-1:0]       value;
        logic signed [PRIO_W-1:0]  prio;
    } t_cmd;

endpackage

### rtl/spq_front.sv
module spq_front import spq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [VAL_IN_W-1:0]      i_item_value,
    input  logic signed [PRIO_W-1:0] i_priority_req,
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd,
    input  logic                     i_cmd_take
);

    t_cmd              r_fifo [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_fill;
    t_cmd              n_cmd;
    logic              push;
    logic              pop;

    // Decode the function code into a command
    always_comb begin
        n_cmd.value = i_item_value;
        n_cmd.prio  = i_priority_req;
        unique case (i_func)
            FUNC_ENQ:  n_cmd.op = OP_ENQ;
            FUNC_DEQ:  n_cmd.op = OP_DEQ;
            FUNC_PEEK: n_cmd.op = OP_PEEK;
            FUNC_CLR:  n_cmd.op = OP_CLR;
            default:   n_cmd.op = OP_CLR;
        endcase
    end

    // Stall only when the command queue is full
    assign o_in_stall  = (r_fill == QCNT_W'(QDEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_take;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_fifo[r_rptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= n_cmd;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + QCNT_W'(1);
                2'b01:   r_fill <= r_fill - QCNT_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### rtl/spq_back.sv
module spq_back import spq_pkg::*; #(
    parameter int DEPTH       = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  t_cmd                      i_cmd,
    output logic                      o_cmd_take,
    input  logic [CFG_W-1:0]          i_max_entries,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [VAL_IN_W-1:0]       o_head_value,
    output logic signed [PRIO_W-1:0]  o_head_priority,
    output logic [COUNT_OUT_W-1:0]    o_count,
    output logic                      o_is_empty,
    output logic                      o_is_full
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    // Sorted slot chain, slot 0 holds the head
    logic [VALUE_WIDTH-1:0]    r_val [DEPTH];
    logic signed [PRIO_W-1:0]  r_pri [DEPTH];
    logic [CW-1:0]             r_count;

    logic                      r_out_valid;
    t_status                   r_status;
    logic [VAL_IN_W-1:0]       r_head_value;
    logic signed [PRIO_W-1:0]  r_head_prio;
    logic [COUNT_OUT_W-1:0]    r_count_out;
    logic                      r_empty;
    logic                      r_full;

    logic                      fire;
    logic [DEPTH-1:0]          le;
    logic [CMPW-1:0]           cap;
    logic                      full_now;
    logic                      empty_now;
    logic                      do_ins;
    logic                      do_shift;
    logic                      show_head;
    t_status                   n_status;
    logic [CW-1:0]             n_count;
    logic [CMPW-1:0]           cnt_ext;
    logic [63:0]               head_ext;
    logic [VALUE_WIDTH-1:0]    new_val;

    // Take a command when the result register is free or draining
    assign fire       = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_cmd_take = fire;

    // Capacity in use is the smaller of the limit and the built depth
    assign cap = (CMPW'(i_max_entries) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(i_max_entries);
    assign full_now  = (CMPW'(r_count) >= cap);
    assign empty_now = (r_count == '0);
    assign new_val   = VALUE_WIDTH'(i_cmd.value);

    // Execute the command
    always_comb begin
        n_status  = ST_OK;
        n_count   = r_count;
        do_ins    = 1'b0;
        do_shift  = 1'b0;
        show_head = 1'b0;
        unique case (i_cmd.op)
            OP_ENQ: begin
                if (full_now) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    do_ins  = fire;
                    n_count = r_count + CW'(1);
                end
            end
            OP_DEQ: begin
                if (empty_now) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    do_shift  = fire;
                    show_head = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_PEEK: begin
                if (empty_now) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    show_head = 1'b1;
                end
            end
            OP_CLR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign cnt_ext  = CMPW'(n_count);
    assign head_ext = 64'(r_val[0]);

    // Per-slot compare: occupied and not after the new entry
    // (a prefix of the chain, since the chain is sorted)
    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        logic                     prev_le;
        logic [VALUE_WIDTH-1:0]   prev_val;
        logic signed [PRIO_W-1:0] prev_pri;
        logic [VALUE_WIDTH-1:0]   next_val;
        logic signed [PRIO_W-1:0] next_pri;

        assign le[g] = (CW'(g) < r_count) && ($signed(r_pri[g]) <= $signed(i_cmd.prio));

        if (g == 0) begin : g_first
            assign prev_le  = 1'b1;
            assign prev_val = new_val;
            assign prev_pri = i_cmd.prio;
        end else begin : g_mid
            assign prev_le  = le[g-1];
            assign prev_val = r_val[g-1];
            assign prev_pri = r_pri[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_val = r_val[g];
            assign next_pri = r_pri[g];
        end else begin : g_inner
            assign next_val = r_val[g+1];
            assign next_pri = r_pri[g+1];
        end

        // Insert here, shift down towards the tail, or shift up on removal
        always_ff @(posedge i_clk) begin
            if (do_ins && !le[g]) begin
                if (prev_le) begin
                    r_val[g] <= new_val;
                    r_pri[g] <= i_cmd.prio;
                end else begin
                    r_val[g] <= prev_val;
                    r_pri[g] <= prev_pri;
                end
            end else if (do_shift) begin
                r_val[g] <= next_val;
                r_pri[g] <= next_pri;
            end
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (fire) begin
            r_count <= n_count;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status     <= n_status;
            r_head_value <= show_head ? head_ext[VAL_IN_W-1:0] : '0;
            r_head_prio  <= show_head ? r_pri[0] : '0;
            r_count_out  <= cnt_ext[COUNT_OUT_W-1:0];
            r_empty      <= (n_count == '0);
            r_full       <= (cnt_ext >= cap);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_head_value    = r_head_value;
    assign o_head_priority = r_head_prio;
    assign o_count         = r_count_out;
    assign o_is_empty      = r_empty;
    assign o_is_full       = r_full;

endmodule

### rtl/sorted_priority_queue.sv
// Bounded priority queue held as a sorted chain of DEPTH slots, lowest
// priority number at the head, equal priorities in arrival order. Each
// request (enqueue, dequeue, peek, clear) gives exactly one result. A
// request enters a two-entry command queue and is executed by the slot
// chain, which compares every slot against the new priority in parallel
// and shifts all slots together on an insert or a removal; one request per
// cycle is sustained while the output is not stalled, and a request passes
// through the command queue and the result register before its result is
// offered. The capacity register (reset 500) is clipped to DEPTH and must
// only be written while no request is in flight. There is no clearing
// pass after reset: slots beyond the count are never read.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH       = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [VAL_IN_W-1:0]       i_item_value,
    input  logic signed [PRIO_W-1:0]  i_priority_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [VAL_IN_W-1:0]       o_head_value,
    output logic signed [PRIO_W-1:0]  o_head_priority,
    output logic [COUNT_OUT_W-1:0]    o_count,
    output logic                      o_is_empty,
    output logic                      o_is_full,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    logic [CFG_W-1:0] r_max_entries;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_take;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_data;
        end
    end

    spq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_item_value   (i_item_value),
        .i_priority_req (i_priority_req),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_take     (cmd_take)
    );

    spq_back #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_take      (cmd_take),
        .i_max_entries   (r_max_entries),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_count         (o_count),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

endmodule

### rtl/spq_checker.sv
`include "sorted_priority_queue_defines.svh"

module spq_props import spq_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [1:0]                o_status,
    input logic [VAL_IN_W-1:0]       o_head_value,
    input logic signed [PRIO_W-1:0]  o_head_priority,
    input logic [COUNT_OUT_W-1:0]    o_count,
    input logic                      o_is_empty,
    input logic                      o_is_full
);

    // A stalled result stays offered and unchanged
    `SPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_status) && $stable(o_head_value) && $stable(o_count),
        "result changed while stalled")

    // Empty flag agrees with the reported count
    `SPQ_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, o_out_valid,
        o_is_empty == (o_count == '0), "empty flag disagrees with count")

    // An overflow leaves the queue full
    `SPQ_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, o_out_valid && (o_status == ST_OVERFLOW),
        o_is_full, "overflow reported on a queue that is not full")

    // An underflow leaves the queue empty and reports no head
    `SPQ_ASSERT_NOW(a_udf_empty, i_clk, i_rst_n, o_out_valid && (o_status == ST_UNDERFLOW),
        o_is_empty && (o_head_value == '0) && (o_head_priority == '0),
        "underflow with a non-empty queue or a head")

endmodule

bind sorted_priority_queue spq_props u_spq_checker (.*);

### test/spq_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and capacity ports of the sorted priority queue,
// keeps its own sorted copy of the entries and checks every result in order.
module spq_checker import spq_pkg::*; #(
    parameter int DEPTH = 512
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [VAL_IN_W-1:0]       i_item_value,
    input  logic signed [PRIO_W-1:0]  i_priority_req,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [1:0]                i_status,
    input  logic [VAL_IN_W-1:0]       i_head_value,
    input  logic signed [PRIO_W-1:0]  i_head_priority,
    input  logic [COUNT_OUT_W-1:0]    i_count,
    input  logic                      i_is_empty,
    input  logic                      i_is_full,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_overflows,
    output int                        o_underflows
);

    typedef struct {
        logic [VAL_IN_W-1:0]       value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    typedef struct {
        t_status                      status;
        logic [VAL_IN_W-1:0]          head_value;
        logic signed [PRIO_W-1:0]     head_prio;
        logic [COUNT_OUT_W-1:0]       count;
        logic                         is_empty;
        logic                         is_full;
    } t_result;

    // Shadow of the queue contents, head first, and results still owed
    t_entry             held_entries[$];
    t_result            owed_results[$];
    logic [CFG_W-1:0]   max_entries = CAP_RESET;

    int fail_count = 0;
    int pending_r = 0;
    int checked = 0;
    int overflows = 0;
    int underflows = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_r;
    assign o_checked    = checked;
    assign o_overflows  = overflows;
    assign o_underflows = underflows;

    // Applies one request to the shadow queue and returns the result it owes
    function automatic t_result apply_queue_command(t_op op, logic [VAL_IN_W-1:0] value,
                                                    logic signed [PRIO_W-1:0] prio);
        t_result      res;
        t_entry       ent;
        int           pos;
        int unsigned  cap;
        cap = (max_entries > DEPTH) ? DEPTH : max_entries;
        res.status     = ST_OK;
        res.head_value = '0;
        res.head_prio  = '0;
        case (op)
            OP_ENQ: begin
                if (held_entries.size() >= cap) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    // equal priorities go behind those already held
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio <= prio)
                        pos++;
                    ent.value = value;
                    ent.prio  = prio;
                    held_entries.insert(pos, ent);
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (held_entries.size() == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.head_value = held_entries[0].value;
                    res.head_prio  = held_entries[0].prio;
                    if (op == OP_DEQ)
                        void'(held_entries.pop_front());
                end
            end
            default: begin
                held_entries.delete();
            end
        endcase
        res.count    = COUNT_OUT_W'(held_entries.size());
        res.is_empty = (held_entries.size() == 0);
        res.is_full  = (held_entries.size() >= cap);
        return res;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Results are compared before this edge's request is predicted
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            held_entries.delete();
            owed_results.delete();
            max_entries <= CAP_RESET;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    check_field("status", want.status, i_status);
                    check_field("head_value", want.head_value, i_head_value);
                    check_field("head_priority", longint'(want.head_prio),
                                longint'(i_head_priority));
                    check_field("count", want.count, i_count);
                    check_field("is_empty", want.is_empty, i_is_empty);
                    check_field("is_full", want.is_full, i_is_full);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = apply_queue_command(t_op'(i_func), i_item_value, i_priority_req);
                if (want.status == ST_OVERFLOW)
                    overflows++;
                if (want.status == ST_UNDERFLOW)
                    underflows++;
                owed_results.push_back(want);
            end
            if (i_cfg_we)
                max_entries <= i_cfg_data;
        end
        pending_r <= owed_results.size();
    end

endmodule

### test/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int HEAVY_PCT   = 82;
    localparam int LIGHT_PCT   = 10;
    localparam int HOLD_CYCLES = 300;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [FUNC_W-1:0]         func = FUNC_PEEK;
    logic [VAL_IN_W-1:0]       item_value = '0;
    logic signed [PRIO_W-1:0]  priority_req = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                status;
    logic [VAL_IN_W-1:0]       head_value;
    logic signed [PRIO_W-1:0]  head_priority;
    logic [COUNT_OUT_W-1:0]    count;
    logic                      is_empty;
    logic                      is_full;
    logic                      cfg_we = 1'b0;
    logic [CFG_W-1:0]          cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int overflows;
    int underflows;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_output = 1'b0;
    int sent_count = 0;
    int cfg_writes = 0;

    sorted_priority_queue i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (func),
        .i_item_value    (item_value),
        .i_priority_req  (priority_req),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_head_value    (head_value),
        .o_head_priority (head_priority),
        .o_count         (count),
        .o_is_empty      (is_empty),
        .o_is_full       (is_full),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    spq_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_func          (func),
        .i_item_value    (item_value),
        .i_priority_req  (priority_req),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_head_value    (head_value),
        .i_head_priority (head_priority),
        .i_count         (count),
        .i_is_empty      (is_empty),
        .i_is_full       (is_full),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_overflows     (overflows),
        .o_underflows    (underflows)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output back-pressure: random stalls, or a solid hold-off when asked
    always @(posedge i_clk) begin
        if (hold_output)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Hard stop for a hung run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int r;
        logic signed [PRIO_W-1:0] p;
        r = $urandom_range(99);
        if (r < 40)
            p = PRIO_W'(int'($urandom_range(6)) - 3);   // narrow band, plenty of ties
        else if (r < 50)
            p = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else
            p = PRIO_W'($urandom);
        return p;
    endfunction

    function automatic logic [VAL_IN_W-1:0] pick_value();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_command(int enq_pct, int deq_pct, int peek_pct);
        int r;
        r = $urandom_range(99);
        if (r < enq_pct)
            return FUNC_ENQ;
        if (r < enq_pct + deq_pct)
            return FUNC_DEQ;
        if (r < enq_pct + deq_pct + peek_pct)
            return FUNC_PEEK;
        return FUNC_CLR;
    endfunction

    // Offers one request and returns once it is taken; valid is left high
    task automatic send_request(logic [FUNC_W-1:0] f, logic [VAL_IN_W-1:0] v,
                                logic signed [PRIO_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        item_value   <= v;
        priority_req <= p;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        sent_count++;
    endtask

    // Waits until every owed result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] cap);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random_phase(logic [CFG_W-1:0] cap, int idle_pct, int stall_pct,
                                    int n_req, int enq_pct, int deq_pct, int peek_pct);
        write_capacity(cap);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        for (int k = 0; k < n_req; k++)
            send_request(pick_command(enq_pct, deq_pct, peek_pct), pick_value(),
                         pick_priority());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, extreme values and priorities, tie order, clear
        send_request(FUNC_PEEK, 32'h0, 16'sh0);
        send_request(FUNC_DEQ, 32'hFFFF_FFFF, 16'sh7FFF);
        send_request(FUNC_ENQ, 32'h0, 16'sh0);
        send_request(FUNC_ENQ, 32'hFFFF_FFFF, 16'sh7FFF);
        send_request(FUNC_ENQ, 32'hA5A5_A5A5, 16'sh8000);
        send_request(FUNC_ENQ, 32'h1, 16'sh0);
        send_request(FUNC_ENQ, 32'h5A5A_5A5A, -16'sd1);
        send_request(FUNC_PEEK, 32'h0, 16'sh0);
        repeat (4) send_request(FUNC_DEQ, 32'h0, 16'sh0);
        send_request(FUNC_CLR, 32'h0, 16'sh0);
        send_request(FUNC_DEQ, 32'h0, 16'sh0);
        send_request(FUNC_CLR, 32'h0, 16'sh0);

        // Capacity of one, then zero: enqueue overflows at once
        write_capacity(10'd1);
        send_request(FUNC_ENQ, 32'h1234_5678, 16'sh0100);
        send_request(FUNC_ENQ, 32'h8765_4321, -16'sd256);
        send_request(FUNC_PEEK, 32'h0, 16'sh0);
        send_request(FUNC_DEQ, 32'h0, 16'sh0);
        write_capacity(10'd0);
        send_request(FUNC_ENQ, 32'hDEAD_BEEF, 16'sh0);
        send_request(FUNC_PEEK, 32'h0, 16'sh0);

        // Capacity lowered below the number of entries held
        write_capacity(CAP_RESET);
        repeat (3) send_request(FUNC_ENQ, pick_value(), pick_priority());
        write_capacity(10'd2);
        send_request(FUNC_ENQ, 32'hCAFE_F00D, 16'sh0);
        repeat (2) send_request(FUNC_DEQ, 32'h0, 16'sh0);
        send_request(FUNC_ENQ, 32'hCAFE_F00D, 16'sh0);

        // Long output hold-off while requests keep coming, so the input stalls
        write_capacity(10'd600);
        fork
            begin
                hold_output <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output <= 1'b0;
            end
            for (int k = 0; k < 40; k++)
                send_request(pick_command(70, 20, 10), pick_value(), pick_priority());
        join

        // Random phases over capacities and idle patterns
        run_random_phase(10'd4, 0, 0, 150, 50, 30, 15);
        run_random_phase(10'd16, HEAVY_PCT, 0, 150, 50, 30, 15);
        run_random_phase(10'h3FF, 0, HEAVY_PCT, 650, 90, 5, 5);
        run_random_phase(10'd3, LIGHT_PCT, LIGHT_PCT, 100, 30, 55, 15);
        run_random_phase(10'd512, 0, 0, 300, 20, 70, 9);
        run_random_phase(10'd1, 0, HEAVY_PCT, 100, 45, 35, 15);
        run_random_phase(10'd0, LIGHT_PCT, LIGHT_PCT, 30, 50, 25, 20);

        recv_stall_pct <= 0;
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d requests across %0d capacity settings, four idle patterns",
                 sent_count, cfg_writes);
        $display("and a long output hold-off: %0d results checked, %0d overflow, %0d underflow",
                 checked, overflows, underflows);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
